### rtl/lhm_pkg.sv
package lhm_pkg;

  localparam int APB_AW = 5;
  localparam int CFG_IW = 3;
  localparam int MS_W   = 26;

  localparam logic [CFG_IW-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_STAB_ON    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MIN_HOSTS  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_RATIO_Q16  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_WARN_SEC   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_FATAL_SEC  = 3'd5;

  localparam logic [31:0]   SILENCE_LIMIT_MS = 32'd5000;
  localparam logic [31:0]   ERROR_HOLD_MS    = 32'd1000;
  localparam logic [MS_W-1:0] MS_PER_SEC     = 26'd1000;

  typedef enum logic [2:0] {
    CODE_NONE             = 3'd0,
    CODE_LINK_DOWN        = 3'd1,
    CODE_TRANSMISSION     = 3'd2,
    CODE_DISCONNECTING    = 3'd3,
    CODE_FATAL_DISCONNECT = 3'd4,
    CODE_ABORTING         = 3'd5
  } code_t;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_ABORT = 2'd1,
    FN_RETRY = 2'd2
  } func_t;

  typedef struct packed {
    logic            enabled;
    logic            stab_on;
    logic [7:0]      min_hosts;
    logic [15:0]     ratio_q16;
    logic [MS_W-1:0] warn_ms;
    logic [MS_W-1:0] fatal_ms;
  } cfg_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] now_ms;
    logic        check_allowed;
    logic        session_present;
    logic        conn_present;
    logic        has_remote;
    logic        rx_idle;
    logic        link_up;
    logic [7:0]  remote_count;
    logic        session_fault;
    logic        ratio_over;
  } stage_t;

  typedef struct packed {
    code_t       cur_code;
    code_t       shown_code;
    logic [31:0] silence_start;
    logic [31:0] last_error_ms;
    logic [31:0] loss_start;
  } state_t;

  typedef struct packed {
    code_t error_code;
    logic  code_changed;
    logic  is_fatal;
  } res_t;

endpackage

### rtl/lhm_in_if.sv
interface lhm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic        check_allowed;
  logic        session_present;
  logic        conn_present;
  logic        has_remote;
  logic        rx_idle;
  logic        link_up;
  logic [7:0]  remote_count;
  logic [31:0] resent_total;
  logic [31:0] sent_total;
  logic        session_fault;

  modport source (
    output valid, func, now_ms, check_allowed, session_present, conn_present,
           has_remote, rx_idle, link_up, remote_count, resent_total, sent_total,
           session_fault,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, check_allowed, session_present, conn_present,
           has_remote, rx_idle, link_up, remote_count, resent_total, sent_total,
           session_fault,
    output ready
  );
endinterface

### rtl/lhm_out_if.sv
interface lhm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] error_code;
  logic       code_changed;
  logic       is_fatal;

  modport source (output valid, error_code, code_changed, is_fatal, input ready);
  modport sink   (input valid, error_code, code_changed, is_fatal, output ready);
endinterface

### rtl/lhm_regs.sv
module lhm_regs
  import lhm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  logic [15:0]       warn_sec;
  logic [15:0]       fatal_sec;
  logic              wr;
  logic [CFG_IW-1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled   <= 1'b1;
      cfg.stab_on   <= 1'b0;
      cfg.min_hosts <= '0;
      cfg.ratio_q16 <= '0;
      cfg.warn_ms   <= '0;
      cfg.fatal_ms  <= '0;
      warn_sec      <= '0;
      fatal_sec     <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ENABLE:    cfg.enabled   <= pwdata[0];
        REG_STAB_ON:   cfg.stab_on   <= pwdata[0];
        REG_MIN_HOSTS: cfg.min_hosts <= pwdata[7:0];
        REG_RATIO_Q16: cfg.ratio_q16 <= pwdata[15:0];
        REG_WARN_SEC: begin
          warn_sec    <= pwdata[15:0];
          cfg.warn_ms <= MS_W'(pwdata[15:0]) * MS_PER_SEC;
        end
        REG_FATAL_SEC: begin
          fatal_sec    <= pwdata[15:0];
          cfg.fatal_ms <= MS_W'(pwdata[15:0]) * MS_PER_SEC;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE:    prdata = {31'd0, cfg.enabled};
      REG_STAB_ON:   prdata = {31'd0, cfg.stab_on};
      REG_MIN_HOSTS: prdata = {24'd0, cfg.min_hosts};
      REG_RATIO_Q16: prdata = {16'd0, cfg.ratio_q16};
      REG_WARN_SEC:  prdata = {16'd0, warn_sec};
      REG_FATAL_SEC: prdata = {16'd0, fatal_sec};
      default:       prdata = '0;
    endcase
  end

endmodule

### rtl/lhm_eval.sv
module lhm_eval
  import lhm_pkg::*;
(
  input  cfg_t   cfg,
  input  stage_t s,
  input  state_t state,
  output state_t state_next,
  output res_t   res
);

  logic [31:0] st;
  logic [31:0] sms;
  logic [31:0] ls;
  logic [31:0] unst;
  code_t       code;

  always_comb begin
    st         = state.silence_start;
    sms        = '0;
    ls         = state.loss_start;
    unst       = '0;
    code       = CODE_NONE;
    state_next = state;
    res.error_code   = state.cur_code;
    res.code_changed = 1'b0;

    case (s.func)
      FN_ABORT: begin
        state_next.cur_code   = CODE_ABORTING;
        state_next.shown_code = CODE_ABORTING;
        res.error_code        = CODE_ABORTING;
        res.code_changed      = (state.shown_code != CODE_ABORTING);
      end
      FN_RETRY: state_next.shown_code = CODE_NONE;
      FN_TICK: begin
        if (!cfg.enabled) begin
          state_next.cur_code = CODE_NONE;
          res.error_code      = CODE_NONE;
        end else begin
          if (s.check_allowed && s.session_present) begin
            if (s.conn_present && s.has_remote && s.rx_idle) begin
              st = (state.silence_start == '0) ? s.now_ms : state.silence_start;
              state_next.silence_start = st;
              sms = s.now_ms - st;
              if ((sms > SILENCE_LIMIT_MS && s.remote_count > 8'd1) || !s.link_up) begin
                state_next.last_error_ms = s.now_ms;
                code = CODE_TRANSMISSION;
              end
            end else if ((s.now_ms - state.last_error_ms) > ERROR_HOLD_MS) begin
              state_next.silence_start = '0;
              state_next.last_error_ms = '0;
            end

            if (s.conn_present && code == CODE_NONE && cfg.stab_on &&
                s.remote_count >= cfg.min_hosts) begin
              if (s.ratio_over) begin
                ls = (state.loss_start == '0) ? s.now_ms : state.loss_start;
                state_next.loss_start = ls;
                unst = s.now_ms - ls;
                if (unst > 32'(cfg.warn_ms))  code = CODE_TRANSMISSION;
                if (unst > 32'(cfg.fatal_ms)) code = CODE_FATAL_DISCONNECT;
              end else begin
                state_next.loss_start = '0;
              end
            end

            if (!s.has_remote && s.session_fault && state_next.last_error_ms != '0)
              code = CODE_DISCONNECTING;
          end

          if (s.check_allowed && code != CODE_TRANSMISSION && !s.link_up)
            code = (state.shown_code != CODE_ABORTING) ? CODE_LINK_DOWN : CODE_ABORTING;

          state_next.cur_code   = code;
          state_next.shown_code = code;
          res.error_code        = code;
          res.code_changed      = (state.shown_code != code);
        end
      end
      default: ;
    endcase

    res.is_fatal = (res.error_code == CODE_FATAL_DISCONNECT) ||
                   (res.error_code == CODE_ABORTING);
  end

endmodule

### rtl/link_health_monitor_top.sv
// channel  | dir | beat
// item     | in  | func, now_ms, link/session flags, remote_count, totals
// result   | out | error_code, code_changed, is_fatal
// apb      | in  | register writes and reads, pready tied high
//
// Item goes to stage 1, then the result register; one item per cycle if result.ready.
// Stage 1 registers the beat and the retransmit ratio compare (one 16x33 multiply).
// Stage 2 evaluates against the state registers and loads the result register.
// A stalled result holds stage 2; stage 1 still fills, then item.ready drops.
// Synchronous reset clears state and valids and sets config defaults, not stage data.
module link_health_monitor_top
  import lhm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lhm_in_if.sink            item,
  lhm_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t   cfg;
  stage_t s1;
  stage_t s1_next;
  logic   v1;
  logic   ov;
  logic   adv;
  state_t state;
  state_t state_next;
  res_t   ev_res;
  res_t   out_res;

  logic [32:0] total;
  logic [32:0] total_nz;
  logic [48:0] thr;
  logic [48:0] scaled;

  assign pready = 1'b1;

  lhm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign total    = {1'b0, item.sent_total} + {1'b0, item.resent_total};
  assign total_nz = (total == '0) ? 33'd1 : total;
  assign thr      = 49'(cfg.ratio_q16) * 49'(total_nz);
  assign scaled   = {1'b0, item.resent_total, 16'd0};

  always_comb begin
    s1_next.func            = func_t'(item.func);
    s1_next.now_ms          = item.now_ms;
    s1_next.check_allowed   = item.check_allowed;
    s1_next.session_present = item.session_present;
    s1_next.conn_present    = item.conn_present;
    s1_next.has_remote      = item.has_remote;
    s1_next.rx_idle         = item.rx_idle;
    s1_next.link_up         = item.link_up;
    s1_next.remote_count    = item.remote_count;
    s1_next.session_fault   = item.session_fault;
    s1_next.ratio_over      = (scaled > thr);
  end

  lhm_eval u_eval (
    .cfg        (cfg),
    .s          (s1),
    .state      (state),
    .state_next (state_next),
    .res        (ev_res)
  );

  assign adv        = v1 && (!ov || result.ready);
  assign item.ready = !v1 || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      ov    <= 1'b0;
      state <= '{cur_code: CODE_NONE, shown_code: CODE_NONE,
                 silence_start: '0, last_error_ms: '0, loss_start: '0};
    end else begin
      if (item.valid && item.ready) v1 <= 1'b1;
      else if (adv)                 v1 <= 1'b0;
      if (adv)               ov <= 1'b1;
      else if (result.ready) ov <= 1'b0;
      if (adv) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) s1 <= s1_next;
    if (adv) out_res <= ev_res;
  end

  assign result.valid        = ov;
  assign result.error_code   = out_res.error_code;
  assign result.code_changed = out_res.code_changed;
  assign result.is_fatal     = out_res.is_fatal;

  a_shown_tracks: assert property (@(posedge clk) disable iff (rst)
    (adv && ev_res.code_changed) |=> (state.shown_code == out_res.error_code))
    else $error("shown code does not follow a changed result");

  a_abort_sets: assert property (@(posedge clk) disable iff (rst)
    (adv && s1.func == FN_ABORT) |=> (state.cur_code == CODE_ABORTING))
    else $error("abort did not set aborting code");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (v1 && ov && !result.ready))
    else $error("input back-pressured without output stall");

endmodule

### verif/lhm_checker.sv
module lhm_checker
  import lhm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lhm_in_if                 item,
  lhm_out_if                result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fails,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy
  logic        mon_en;
  logic        stab_on;
  logic [7:0]  min_hosts;
  logic [15:0] ratio_q16;
  logic [15:0] warn_sec;
  logic [15:0] fatal_sec;

  // link state
  code_t       cur_code;
  code_t       shown_code;
  logic [31:0] silence_start;
  logic [31:0] last_error_ms;
  logic [31:0] loss_start;

  res_t expected_status[$];

  task automatic report_mismatch(input string what);
    $display("%0t lhm_checker: %s", $time, what);
    fails++;
  endtask

  function automatic res_t status_of(input code_t code, input logic changed);
    res_t r;
    r.error_code   = code;
    r.code_changed = changed;
    r.is_fatal     = (code == CODE_FATAL_DISCONNECT) || (code == CODE_ABORTING);
    return r;
  endfunction

  function automatic logic take_code(input code_t code);
    logic changed;
    changed    = (shown_code != code);
    shown_code = code;
    return changed;
  endfunction

  task automatic predict_status();
    code_t       code;
    logic [31:0] now;
    logic [31:0] since_error;
    logic [31:0] unstable;
    logic [32:0] total;
    logic [63:0] scaled_resent;
    logic [63:0] scaled_limit;
    logic        changed;
    now = item.now_ms;
    if (item.func == FN_ABORT) begin
      cur_code = CODE_ABORTING;
      changed  = take_code(cur_code);
      expected_status.push_back(status_of(cur_code, changed));
    end else if (item.func != FN_TICK) begin
      if (item.func == FN_RETRY) shown_code = CODE_NONE;
      expected_status.push_back(status_of(cur_code, 1'b0));
    end else if (!mon_en) begin
      cur_code = CODE_NONE;
      expected_status.push_back(status_of(CODE_NONE, 1'b0));
    end else begin
      code = CODE_NONE;
      if (item.check_allowed) begin
        if (item.session_present) begin
          since_error = now - last_error_ms;
          if (item.conn_present && item.has_remote && item.rx_idle) begin
            // zero marks "not started", so a start stamped at 0 restarts
            if (silence_start == 32'd0) silence_start = now;
            if (((now - silence_start) > SILENCE_LIMIT_MS && item.remote_count > 8'd1) ||
                !item.link_up) begin
              last_error_ms = now;
              code          = CODE_TRANSMISSION;
            end
          end else if (since_error > ERROR_HOLD_MS) begin
            silence_start = 32'd0;
            last_error_ms = 32'd0;
          end

          if (item.conn_present && code == CODE_NONE && stab_on &&
              item.remote_count >= min_hosts) begin
            total = {1'b0, item.sent_total} + {1'b0, item.resent_total};
            if (total == 33'd0) total = 33'd1;
            scaled_resent = {16'd0, item.resent_total, 16'd0};
            scaled_limit  = {48'd0, ratio_q16} * {31'd0, total};
            if (scaled_resent > scaled_limit) begin
              if (loss_start == 32'd0) loss_start = now;
              unstable = now - loss_start;
              if (unstable > {16'd0, warn_sec} * 32'(MS_PER_SEC))  code = CODE_TRANSMISSION;
              if (unstable > {16'd0, fatal_sec} * 32'(MS_PER_SEC)) code = CODE_FATAL_DISCONNECT;
            end else begin
              loss_start = 32'd0;
            end
          end

          if (!item.has_remote && item.session_fault && last_error_ms != 32'd0)
            code = CODE_DISCONNECTING;
        end

        if (code != CODE_TRANSMISSION && !item.link_up)
          code = (shown_code != CODE_ABORTING) ? CODE_LINK_DOWN : CODE_ABORTING;
      end
      cur_code = code;
      changed  = take_code(cur_code);
      expected_status.push_back(status_of(cur_code, changed));
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      mon_en        = 1'b1;
      stab_on       = 1'b0;
      min_hosts     = '0;
      ratio_q16     = '0;
      warn_sec      = '0;
      fatal_sec     = '0;
      cur_code      = CODE_NONE;
      shown_code    = CODE_NONE;
      silence_start = '0;
      last_error_ms = '0;
      loss_start    = '0;
      fails         = 0;
      expected_status.delete();
    end else begin
      // result first: a beat accepted now cannot come out at this edge
      if (result.valid && result.ready) begin
        if (expected_status.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat code %0d", result.error_code));
        end else begin
          want = expected_status.pop_front();
          if (result.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, want %0d",
                                      result.error_code, want.error_code));
          if (result.code_changed !== want.code_changed)
            report_mismatch($sformatf("code_changed %b, want %b",
                                      result.code_changed, want.code_changed));
          if (result.is_fatal !== want.is_fatal)
            report_mismatch($sformatf("is_fatal %b, want %b",
                                      result.is_fatal, want.is_fatal));
        end
      end
      if (item.valid && item.ready) predict_status();
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_ENABLE:    mon_en    = pwdata[0];
          REG_STAB_ON:   stab_on   = pwdata[0];
          REG_MIN_HOSTS: min_hosts = pwdata[7:0];
          REG_RATIO_Q16: ratio_q16 = pwdata[15:0];
          REG_WARN_SEC:  warn_sec  = pwdata[15:0];
          REG_FATAL_SEC: fatal_sec = pwdata[15:0];
          default: ;
        endcase
      end
    end
    pending <= expected_status.size();
  end

endmodule

### verif/tb_top.sv
module tb_top;
  import lhm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic        allowed;
    logic        session;
    logic        conn;
    logic        remote;
    logic        idle;
    logic        link;
    logic [7:0]  hosts;
    logic [31:0] resent;
    logic [31:0] sent;
    logic        fault;
  } beat_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  lhm_in_if  in_ch ();
  lhm_out_if out_ch ();

  int fails, pending;
  int cycles = 0;

  logic sink_ready = 1'b0;
  int   sink_mode  = 0;
  int   sink_span  = 0;

  int          burst_left = 0;
  logic [31:0] clock_ms;
  logic [31:0] sent_acc, resent_acc;
  logic        lossy, quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  link_health_monitor_top dut (
    .clk, .rst,
    .item   (in_ch),
    .result (out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lhm_checker chk (
    .clk, .rst,
    .item   (in_ch),
    .result (out_ch),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fails, .pending
  );

  assign out_ch.ready = sink_ready;

  // result side stalls in spans of differing density
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      sink_mode  <= 0;
      sink_span  <= 0;
    end else begin
      if (sink_span == 0) begin
        sink_mode <= $urandom_range(0, 3);
        sink_span <= $urandom_range(20, 200);
      end else begin
        sink_span <= sink_span - 1;
      end
      case (sink_mode)
        0:       sink_ready <= 1'b1;
        1:       sink_ready <= 1'($urandom_range(0, 1));
        2:       sink_ready <= ($urandom_range(0, 4) == 0);
        default: sink_ready <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic beat_t tick_beat(input logic [31:0] now, input logic [5:0] flags,
                                      input logic [7:0] hosts, input logic [31:0] resent,
                                      input logic [31:0] sent, input logic fault);
    beat_t b;
    b.func = FN_TICK;
    b.now_ms = now;
    {b.allowed, b.session, b.conn, b.remote, b.idle, b.link} = flags;
    b.hosts  = hosts;
    b.resent = resent;
    b.sent   = sent;
    b.fault  = fault;
    return b;
  endfunction

  task automatic feed(input beat_t b);
    int gap;
    in_ch.valid           <= 1'b1;
    in_ch.func            <= b.func;
    in_ch.now_ms          <= b.now_ms;
    in_ch.check_allowed   <= b.allowed;
    in_ch.session_present <= b.session;
    in_ch.conn_present    <= b.conn;
    in_ch.has_remote      <= b.remote;
    in_ch.rx_idle         <= b.idle;
    in_ch.link_up         <= b.link;
    in_ch.remote_count    <= b.hosts;
    in_ch.resent_total    <= b.resent;
    in_ch.sent_total      <= b.sent;
    in_ch.session_fault   <= b.fault;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [31:0] val,
                           input int width);
    logic [31:0] keep;
    keep = (32'd1 << width) - 32'd1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (val & keep) | ($urandom & ~keep);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [31:0] en, input logic [31:0] stab,
                           input logic [31:0] hosts, input logic [31:0] ratio,
                           input logic [31:0] warn, input logic [31:0] fatal);
    cfg_write(REG_ENABLE, en, 1);
    cfg_write(REG_STAB_ON, stab, 1);
    cfg_write(REG_MIN_HOSTS, hosts, 8);
    cfg_write(REG_RATIO_Q16, ratio, 16);
    cfg_write(REG_WARN_SEC, warn, 16);
    cfg_write(REG_FATAL_SEC, fatal, 16);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly coherent ticks: rising time, cumulative totals, sticky quiet/lossy
  // modes; the rest is noise
  task automatic random_beat(output beat_t b);
    b.func = FN_TICK;
    if ($urandom_range(0, 99) < 15) begin
      b.func   = 2'($urandom_range(0, 3));
      b.now_ms = $urandom;
      {b.allowed, b.session, b.conn, b.remote, b.idle, b.link} = 6'($urandom);
      b.hosts  = 8'($urandom);
      b.resent = $urandom;
      b.sent   = $urandom;
      b.fault  = 1'($urandom);
    end else begin
      if ($urandom_range(0, 19) == 0)
        b.func = ($urandom_range(0, 1) != 0) ? FN_ABORT : FN_RETRY;
      if ($urandom_range(0, 49) == 0) begin
        sent_acc   = '0;
        resent_acc = '0;
      end
      if ($urandom_range(0, 29) == 0) lossy = !lossy;
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      clock_ms += ($urandom_range(0, 9) == 0) ? $urandom_range(1500, 9000)
                                               : $urandom_range(0, 1200);
      sent_acc   += $urandom_range(0, 300);
      resent_acc += lossy ? $urandom_range(20, 300) : $urandom_range(0, 4);
      b.now_ms  = clock_ms;
      b.allowed = ($urandom_range(0, 9) != 0);
      b.session = ($urandom_range(0, 9) != 0);
      b.conn    = quiet || ($urandom_range(0, 7) != 0);
      b.remote  = quiet || ($urandom_range(0, 4) != 0);
      b.idle    = quiet || ($urandom_range(0, 2) != 0);
      b.link    = ($urandom_range(0, 6) != 0);
      case ($urandom_range(0, 9))
        0:       b.hosts = 8'd255;
        1:       b.hosts = 8'($urandom);
        default: b.hosts = 8'($urandom_range(0, 4));
      endcase
      b.resent = resent_acc;
      b.sent   = sent_acc;
      b.fault  = ($urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    beat_t b;
    int    ph;
    int    k;
    int    warn_s;
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.func            = FN_TICK;
    in_ch.now_ms          = '0;
    in_ch.check_allowed   = 1'b0;
    in_ch.session_present = 1'b0;
    in_ch.conn_present    = 1'b0;
    in_ch.has_remote      = 1'b0;
    in_ch.rx_idle         = 1'b0;
    in_ch.link_up         = 1'b0;
    in_ch.remote_count    = '0;
    in_ch.resent_total    = '0;
    in_ch.sent_total      = '0;
    in_ch.session_fault   = 1'b0;
    lossy      = 1'b0;
    quiet      = 1'b0;
    sent_acc   = '0;
    resent_acc = '0;
    clock_ms   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: silence, hold-off, faults, link loss, events
    // flags are {allowed, session, conn, remote, idle, link}
    feed(tick_beat(32'd0, 6'b111111, 8'd2, '0, '0, 1'b0));   // start stamped at zero
    feed(tick_beat(32'd100, 6'b111111, 8'd2, '0, '0, 1'b0));
    feed(tick_beat(32'd6000, 6'b111111, 8'd2, '0, '0, 1'b0));  // long silence
    feed(tick_beat(32'd6500, 6'b111101, 8'd2, '0, '0, 1'b0));
    feed(tick_beat(32'd7000, 6'b110001, 8'd0, '0, '0, 1'b1));  // fault after error
    feed(tick_beat(32'd7100, 6'b100000, 8'd0, '0, '0, 1'b0));  // link down
    b = tick_beat(32'd7150, 6'b100000, 8'd0, '0, '0, 1'b0);
    b.func = FN_ABORT;
    feed(b);
    feed(tick_beat(32'd7200, 6'b100000, 8'd0, '0, '0, 1'b0));  // abort stays shown
    b.func = FN_RETRY;
    feed(b);
    b.func = FN_UNUSED;
    feed(b);
    feed(tick_beat(32'd7300, 6'b000000, 8'd0, '0, '0, 1'b0));
    feed(tick_beat(32'hFFFF_FFFF, 6'b111111, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    feed(tick_beat(32'h0000_1400, 6'b111110, 8'd1, '0, '0, 1'b0));  // wrap, idle, no link
    feed(tick_beat(32'h5555_AAAA, 6'b010101, 8'hAA, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0));

    drain();
    configure(0, 1, 0, 0, 0, 0);
    feed(tick_beat(32'd9000, 6'b111110, 8'd3, 32'd5, 32'd5, 1'b1));
    b.func = FN_ABORT;
    feed(b);

    // ratio test at the low extremes: zero threshold, zero times, max hosts
    drain();
    configure(1, 1, 255, 0, 0, 0);
    feed(tick_beat(32'd1000, 6'b111011, 8'd255, 32'd0, 32'd0, 1'b0));
    feed(tick_beat(32'd2000, 6'b111011, 8'd255, 32'd1, 32'd0, 1'b0));
    feed(tick_beat(32'd2001, 6'b111011, 8'd255, 32'd1, 32'd0, 1'b0));
    feed(tick_beat(32'd2500, 6'b111011, 8'd254, 32'd1, 32'd0, 1'b0));
    feed(tick_beat(32'd3000, 6'b111011, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));

    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(1, 1, 0, $urandom_range(2000, 20000), 1, 3);
        1: configure(1, 1, 255, 65535, 65535, 65535);
        2: configure(1, 1, 0, 0, 0, 0);
        3: configure(0, $urandom, $urandom, $urandom, $urandom, $urandom);
        4: begin
          warn_s = $urandom_range(0, 4);
          configure(1, 1, $urandom_range(0, 3), $urandom_range(2000, 30000),
                    warn_s, warn_s + $urandom_range(0, 4));
        end
        default: configure(1, 0, $urandom_range(0, 4), $urandom, 2, 5);
      endcase
      clock_ms = (ph == 2) ? 32'hFFFF_C000 : 32'($urandom_range(1, 100000));
      for (k = 0; k < 125; k++) begin
        if (k == 60) drain();
        random_beat(b);
        feed(b);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
